[rtl/core/bba_pkg.sv]
// Shared constants, types and helper functions of the buddy block allocator.
`timescale 1ns / 1ps

package bba_pkg;

    // Geometry of the pool.
    localparam int ADDR_BITS      = 16;
    localparam int MIN_BLOCK_BITS = 3;
    localparam int TIER_COUNT     = ADDR_BITS + 1;
    localparam int SLOT_BITS      = ADDR_BITS - MIN_BLOCK_BITS;
    localparam int SLOTS          = 1 << SLOT_BITS;
    localparam int OFF_BITS       = ADDR_BITS + 1;
    localparam int CNT_BITS       = SLOT_BITS + 1;
    localparam int TIER_IDX_BITS  = $clog2(TIER_COUNT);

    // Field widths of the channels and registers.
    localparam int OPCODE_BITS  = 2;
    localparam int STATUS_BITS  = 2;
    localparam int BUS_ADDR_BITS = 48;
    localparam int TIER_BITS    = 5;
    localparam int BYTES_BITS   = 17;
    localparam int CFG_IDX_BITS = 2;

    // Opcodes.
    localparam logic [OPCODE_BITS-1:0] OP_ALLOC = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_FREE  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_QUERY = 2'd2;

    // Status codes.
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_FAIL      = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_NOT_ALLOC = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_BYTES = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_TIER   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_TIER   = 2'd3;

    // Configuration reset values.
    localparam logic [BYTES_BITS-1:0] POOL_BYTES_RST = 17'd65536;
    localparam logic [TIER_BITS-1:0]  MIN_TIER_RST   = 5'd3;
    localparam logic [TIER_BITS-1:0]  MAX_TIER_RST   = 5'd16;

    // One link word of a free list.
    typedef struct packed {
        logic                 ok;
        logic [ADDR_BITS-1:0] nxt;
    } link_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                   idle;
        logic                   clr_wr;
        logic                   a_init;
        logic                   pop_rd;
        logic                   pop_wr;
        logic                   split;
        logic                   a_mark;
        logic                   merge;
        logic                   f_push;
        logic                   pbit;
        logic                   q_init;
        logic                   tier_inc;
        logic                   walk_init;
        logic                   w_rd;
        logic                   w_adv;
        logic                   unlink;
        logic                   x_rd;
        logic                   h_rd;
        logic                   h_adv;
        logic                   res_wr;
        logic [STATUS_BITS-1:0] res_status;
        logic                   res_alloc;
        logic                   res_query;
        logic                   out_load;
    } bba_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic                   accept;
        logic [OPCODE_BITS-1:0] op;
        logic                   clr_last;
        logic                   a_bad;
        logic                   f_tier_bad;
        logic                   f_fit;
        logic                   f_can_merge;
        logic                   q_over;
        logic                   k_at_e;
        logic                   tgt_fits;
        logic                   pair_q;
        logic                   walk_live;
        logic                   walk_hit;
        logic                   h_end;
        logic                   out_free;
    } bba_stat_t;

    // Pair-bit slot of the buddy pair that holds the block at off of tier e.
    function automatic logic [SLOT_BITS-1:0] pair_slot(input logic [ADDR_BITS-1:0] off,
                                                       input logic [TIER_BITS-1:0] e);
        logic [ADDR_BITS-1:0] top;
        logic [ADDR_BITS-1:0] sum;
        top = '0;
        sum = '0;
        if (e < TIER_BITS'(ADDR_BITS)) begin
            top = ADDR_BITS'(1) << (TIER_BITS'(ADDR_BITS - 1) - e);
            sum = top + (off >> (e + TIER_BITS'(1)));
        end
        return sum[SLOT_BITS-1:0];
    endfunction

    // True when a block of tier e at off is aligned and ends inside the pool.
    function automatic logic fits(input logic [OFF_BITS-1:0] off,
                                  input logic [TIER_BITS-1:0] e,
                                  input logic [OFF_BITS-1:0] sz);
        logic [OFF_BITS-1:0] n;
        n = OFF_BITS'(1) << e;
        return (off < sz) && ((off & (n - OFF_BITS'(1))) == '0) && (n <= sz - off);
    endfunction

endpackage

[rtl/core/bba_if.sv]
// Channel interfaces of the buddy block allocator: request, response and configuration.
`timescale 1ns / 1ps

interface bba_req_if;
    import bba_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OPCODE_BITS-1:0]   opcode;
    logic [BUS_ADDR_BITS-1:0] block_addr;
    logic [TIER_BITS-1:0]     req_tier;
    modport source (output valid, output opcode, output block_addr, output req_tier,
                    input ready);
    modport sink (input valid, input opcode, input block_addr, input req_tier,
                  output ready);
endinterface

interface bba_rsp_if;
    import bba_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [STATUS_BITS-1:0]   status;
    logic [BUS_ADDR_BITS-1:0] result_addr;
    logic [TIER_BITS-1:0]     found_tier;
    modport source (output valid, output status, output result_addr, output found_tier,
                    input ready);
    modport sink (input valid, input status, input result_addr, input found_tier,
                  output ready);
endinterface

interface bba_cfg_if;
    import bba_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  reg_index;
    logic [BUS_ADDR_BITS-1:0] wdata;
    modport source (output valid, output reg_index, output wdata, input ready);
    modport sink (input valid, input reg_index, input wdata, output ready);
endinterface

[rtl/core/bba_dpath.sv]
// Datapath of the buddy block allocator: registers, list heads, link and pair-bit memories.
`timescale 1ns / 1ps

module bba_dpath (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::bba_cmd_t  cmd,
    output bba_pkg::bba_stat_t stat,
    bba_req_if.sink            req,
    bba_rsp_if.source          rsp,
    bba_cfg_if.sink            cfg
);
    import bba_pkg::*;

    // Configuration registers.
    logic [BUS_ADDR_BITS-1:0] base_reg;
    logic [BYTES_BITS-1:0]    bytes_reg;
    logic [TIER_BITS-1:0]     min_reg;
    logic [TIER_BITS-1:0]     max_reg;

    // Operation registers.
    logic [OPCODE_BITS-1:0] op_reg;
    logic [OFF_BITS-1:0]    off_reg;
    logic                   far_reg;
    logic [TIER_BITS-1:0]   tier_reg;
    logic [TIER_BITS-1:0]   k_reg;
    logic [ADDR_BITS-1:0]   blk_reg;

    // List walk and pair scan registers.
    logic [ADDR_BITS-1:0] cur_reg;
    logic [ADDR_BITS-1:0] prev_reg;
    logic                 wok_reg;
    logic                 hp_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [TIER_BITS-1:0] d_reg;
    logic [SLOT_BITS-1:0] j_reg;
    logic [SLOT_BITS-1:0] clr_reg;

    // Free list heads, one per tier.
    logic [ADDR_BITS-1:0] head_reg [TIER_COUNT];
    logic                 hok_reg  [TIER_COUNT];

    // Memories.
    link_t link_mem [SLOTS];
    link_t link_q;
    logic  pair_mem [SLOTS];
    logic  pair_q;

    // Result and output registers.
    logic [STATUS_BITS-1:0]   res_status_reg;
    logic [BUS_ADDR_BITS-1:0] res_addr_reg;
    logic [TIER_BITS-1:0]     res_found_reg;
    logic                     out_vld_reg;
    logic [STATUS_BITS-1:0]   out_status_reg;
    logic [BUS_ADDR_BITS-1:0] out_addr_reg;
    logic [TIER_BITS-1:0]     out_found_reg;

    // Combinational values.
    logic [TIER_BITS-1:0]     lo;
    logic [TIER_BITS-1:0]     hi;
    logic [OFF_BITS-1:0]      sz;
    logic [OFF_BITS-1:0]      bit_e;
    logic [OFF_BITS-1:0]      buddy;
    logic [OFF_BITS-1:0]      tgt;
    logic [TIER_BITS-1:0]     eff;
    logic [TIER_BITS-1:0]     pick;
    logic                     any;
    logic [TIER_IDX_BITS-1:0] hr_idx;
    logic [ADDR_BITS-1:0]     head_rd;
    logic                     hok_rd;
    logic [TIER_BITS-1:0]     k_dn;
    logic [ADDR_BITS-1:0]     split_x;
    logic                     lw_en;
    logic [SLOT_BITS-1:0]     lw_addr;
    link_t                    lw_data;
    logic                     lr_en;
    logic [SLOT_BITS-1:0]     lr_addr;
    logic                     hw_en;
    logic [TIER_IDX_BITS-1:0] hw_idx;
    logic [ADDR_BITS-1:0]     hw_head;
    logic                     hw_ok;
    logic                     pw_en;
    logic                     pw_data;
    logic                     pr_en;
    logic [SLOT_BITS-1:0]     p_addr;
    logic [SLOT_BITS-1:0]     hs_addr;
    logic                     j_last;
    logic [BUS_ADDR_BITS-1:0] off48;

    // Effective tier range and pool size.
    always_comb
    begin
        lo = (min_reg < TIER_BITS'(MIN_BLOCK_BITS)) ? TIER_BITS'(MIN_BLOCK_BITS) : min_reg;
        hi = (max_reg > TIER_BITS'(ADDR_BITS)) ? TIER_BITS'(ADDR_BITS) : max_reg;
        sz = (bytes_reg > BYTES_BITS'(1 << ADDR_BITS)) ? OFF_BITS'(1 << ADDR_BITS)
                                                       : OFF_BITS'(bytes_reg);
    end

    // Buddy and target of the current check.
    assign bit_e = OFF_BITS'(1) << tier_reg;
    assign buddy = off_reg ^ bit_e;
    assign tgt   = (op_reg == OP_FREE) ? buddy : off_reg;
    assign eff   = (tier_reg < lo) ? lo : tier_reg;
    assign off48 = req.block_addr - base_reg;

    // Smallest non-empty tier within the allocate range.
    always_comb
    begin
        pick = '0;
        any  = 1'b0;
        for (int i = TIER_COUNT - 1; i >= 0; i--) begin
            if (hok_reg[i] && (TIER_BITS'(i) >= eff) && (TIER_BITS'(i) <= hi)) begin
                pick = TIER_BITS'(i);
                any  = 1'b1;
            end
        end
    end

    // Head read port.
    assign k_dn = k_reg - TIER_BITS'(1);
    always_comb
    begin
        if (cmd.pop_rd) begin
            hr_idx = k_reg[TIER_IDX_BITS-1:0];
        end else if (cmd.split) begin
            hr_idx = k_dn[TIER_IDX_BITS-1:0];
        end else begin
            hr_idx = tier_reg[TIER_IDX_BITS-1:0];
        end
    end
    assign head_rd = head_reg[hr_idx];
    assign hok_rd  = hok_reg[hr_idx];
    assign split_x = blk_reg ^ (ADDR_BITS'(1) << k_dn);

    // Link memory port selection.
    always_comb
    begin
        lw_en   = 1'b0;
        lw_addr = '0;
        lw_data = '0;
        if (cmd.split) begin
            lw_en   = 1'b1;
            lw_addr = split_x[ADDR_BITS-1:MIN_BLOCK_BITS];
            lw_data = '{ok: hok_rd, nxt: head_rd};
        end else if (cmd.f_push) begin
            lw_en   = 1'b1;
            lw_addr = off_reg[ADDR_BITS-1:MIN_BLOCK_BITS];
            lw_data = '{ok: hok_rd, nxt: head_rd};
        end else if (cmd.unlink && hp_reg) begin
            lw_en   = 1'b1;
            lw_addr = prev_reg[ADDR_BITS-1:MIN_BLOCK_BITS];
            lw_data = link_q;
        end
        lr_en   = cmd.pop_rd || cmd.w_rd;
        lr_addr = cmd.pop_rd ? head_rd[ADDR_BITS-1:MIN_BLOCK_BITS]
                             : cur_reg[ADDR_BITS-1:MIN_BLOCK_BITS];
    end

    // Head write port.
    always_comb
    begin
        hw_en   = 1'b0;
        hw_idx  = tier_reg[TIER_IDX_BITS-1:0];
        hw_head = '0;
        hw_ok   = 1'b0;
        if (cmd.pop_wr) begin
            hw_en   = 1'b1;
            hw_idx  = k_reg[TIER_IDX_BITS-1:0];
            hw_head = link_q.nxt;
            hw_ok   = link_q.ok;
        end else if (cmd.split) begin
            hw_en   = 1'b1;
            hw_idx  = k_dn[TIER_IDX_BITS-1:0];
            hw_head = split_x;
            hw_ok   = 1'b1;
        end else if (cmd.f_push) begin
            hw_en   = 1'b1;
            hw_head = off_reg[ADDR_BITS-1:0];
            hw_ok   = 1'b1;
        end else if (cmd.unlink && !hp_reg) begin
            hw_en   = 1'b1;
            hw_head = link_q.nxt;
            hw_ok   = link_q.ok;
        end
    end

    // Pair-bit memory port selection.
    assign hs_addr = pair_slot(tgt[ADDR_BITS-1:0], d_reg) + j_reg;
    assign j_last  = (j_reg == ((SLOT_BITS'(1) << (tier_reg - d_reg - TIER_BITS'(1)))
                                - SLOT_BITS'(1)));
    always_comb
    begin
        pw_en   = 1'b0;
        pw_data = 1'b0;
        pr_en   = 1'b0;
        p_addr  = pair_slot(off_reg[ADDR_BITS-1:0], tier_reg);
        if (cmd.clr_wr) begin
            pw_en  = 1'b1;
            p_addr = clr_reg;
        end else if (cmd.a_mark) begin
            pw_en   = 1'b1;
            pw_data = 1'b1;
            p_addr  = pair_slot(blk_reg, tier_reg);
        end else if (cmd.merge) begin
            pw_en = 1'b1;
        end else if (cmd.f_push) begin
            pw_en   = 1'b1;
            pw_data = cmd.pbit;
        end else if (cmd.x_rd) begin
            pr_en  = 1'b1;
            p_addr = pair_slot(tgt[ADDR_BITS-1:0], tier_reg);
        end else if (cmd.h_rd) begin
            pr_en  = 1'b1;
            p_addr = hs_addr;
        end
    end

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (lw_en) begin
            link_mem[lw_addr] <= lw_data;
        end
        if (lr_en) begin
            link_q <= link_mem[lr_addr];
        end
        if (pw_en) begin
            pair_mem[p_addr] <= pw_data;
        end
        if (pr_en) begin
            pair_q <= pair_mem[p_addr];
        end
    end

    // Control registers: configuration, head valid bits, clear counter, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            base_reg    <= '0;
            bytes_reg   <= POOL_BYTES_RST;
            min_reg     <= MIN_TIER_RST;
            max_reg     <= MAX_TIER_RST;
            clr_reg     <= '0;
            out_vld_reg <= 1'b0;
            for (int i = 0; i < TIER_COUNT; i++) begin
                hok_reg[i] <= 1'b0;
            end
        end else begin
            if (cfg.valid) begin
                unique case (cfg.reg_index)
                    CFG_POOL_BASE:  base_reg  <= cfg.wdata;
                    CFG_POOL_BYTES: bytes_reg <= cfg.wdata[BYTES_BITS-1:0];
                    CFG_MIN_TIER:   min_reg   <= cfg.wdata[TIER_BITS-1:0];
                    CFG_MAX_TIER:   max_reg   <= cfg.wdata[TIER_BITS-1:0];
                endcase
            end
            if (cmd.clr_wr) begin
                clr_reg <= clr_reg + SLOT_BITS'(1);
            end
            if (hw_en) begin
                hok_reg[hw_idx] <= hw_ok;
            end
            if (cmd.out_load) begin
                out_vld_reg <= 1'b1;
            end else if (rsp.ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (hw_en) begin
            head_reg[hw_idx] <= hw_head;
        end
        if (cmd.idle && req.valid) begin
            op_reg   <= req.opcode;
            off_reg  <= off48[OFF_BITS-1:0];
            far_reg  <= |off48[BUS_ADDR_BITS-1:OFF_BITS];
            tier_reg <= req.req_tier;
        end else if (cmd.a_init) begin
            tier_reg <= eff;
        end else if (cmd.q_init) begin
            tier_reg <= lo;
        end else if (cmd.tier_inc) begin
            tier_reg <= tier_reg + TIER_BITS'(1);
        end else if (cmd.merge) begin
            off_reg  <= off_reg & ~bit_e;
            tier_reg <= tier_reg + TIER_BITS'(1);
        end
        if (cmd.a_init) begin
            k_reg <= pick;
        end else if (cmd.split) begin
            k_reg <= k_dn;
        end
        if (cmd.pop_rd) begin
            blk_reg <= head_rd;
        end
        // List walk state.
        if (cmd.walk_init) begin
            cur_reg <= head_rd;
            wok_reg <= hok_rd;
            hp_reg  <= 1'b0;
            cnt_reg <= '0;
            d_reg   <= lo;
            j_reg   <= '0;
        end else begin
            if (cmd.w_adv) begin
                prev_reg <= cur_reg;
                hp_reg   <= 1'b1;
                wok_reg  <= link_q.ok;
                cur_reg  <= link_q.nxt;
                cnt_reg  <= cnt_reg + CNT_BITS'(1);
            end
            if (cmd.h_adv) begin
                if (j_last) begin
                    d_reg <= d_reg + TIER_BITS'(1);
                    j_reg <= '0;
                end else begin
                    j_reg <= j_reg + SLOT_BITS'(1);
                end
            end
        end
        // Result of the current word.
        if (cmd.res_wr) begin
            res_status_reg <= cmd.res_status;
            res_addr_reg   <= cmd.res_alloc ? base_reg + BUS_ADDR_BITS'(blk_reg) : '0;
            res_found_reg  <= cmd.res_query ? tier_reg : '0;
        end
        if (cmd.out_load) begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_found_reg  <= res_found_reg;
        end
    end

    // Channel outputs.
    assign req.ready       = cmd.idle;
    assign cfg.ready       = 1'b1;
    assign rsp.valid       = out_vld_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.result_addr = out_addr_reg;
    assign rsp.found_tier  = out_found_reg;

    // Status to the controller.
    always_comb
    begin
        stat.accept      = cmd.idle && req.valid;
        stat.op          = op_reg;
        stat.clr_last    = (clr_reg == SLOT_BITS'(SLOTS - 1));
        stat.a_bad       = (eff > hi) || !any;
        stat.f_tier_bad  = (tier_reg < lo) || (tier_reg > hi);
        stat.f_fit       = !far_reg && fits(off_reg, tier_reg, sz);
        stat.f_can_merge = (tier_reg < hi) && fits(buddy, tier_reg, sz);
        stat.q_over      = (tier_reg > hi);
        stat.k_at_e      = (k_reg == tier_reg);
        stat.tgt_fits    = !far_reg && fits(tgt, tier_reg, sz);
        stat.pair_q      = pair_q;
        stat.walk_live   = wok_reg && (cnt_reg <= CNT_BITS'(SLOTS));
        stat.walk_hit    = ({1'b0, cur_reg} == tgt);
        stat.h_end       = (d_reg >= tier_reg);
        stat.out_free    = !out_vld_reg || rsp.ready;
    end

endmodule

[rtl/core/bba_ctrl.sv]
// Controller state machine of the buddy block allocator.
`timescale 1ns / 1ps

module bba_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd
);
    import bba_pkg::*;

    localparam logic [4:0] S_CLEAR   = 5'd0;
    localparam logic [4:0] S_IDLE    = 5'd1;
    localparam logic [4:0] S_DECODE  = 5'd2;
    localparam logic [4:0] S_A_POP   = 5'd3;
    localparam logic [4:0] S_A_POPW  = 5'd4;
    localparam logic [4:0] S_A_SPLIT = 5'd5;
    localparam logic [4:0] S_A_MARK  = 5'd6;
    localparam logic [4:0] S_F_CHK   = 5'd7;
    localparam logic [4:0] S_F_MERGE = 5'd8;
    localparam logic [4:0] S_F_PUSH  = 5'd9;
    localparam logic [4:0] S_Q_NEXT  = 5'd10;
    localparam logic [4:0] S_X_FIT   = 5'd11;
    localparam logic [4:0] S_X_PB    = 5'd12;
    localparam logic [4:0] S_W_RD    = 5'd13;
    localparam logic [4:0] S_W_CMP   = 5'd14;
    localparam logic [4:0] S_H_RD    = 5'd15;
    localparam logic [4:0] S_H_CHK   = 5'd16;
    localparam logic [4:0] S_DONE    = 5'd17;

    logic [4:0] state_reg;
    logic [4:0] state_next;
    logic       rm_reg;
    logic       rm_next;
    logic       xres_reg;
    logic       xres_next;
    logic       x_done;
    logic       x_val;

    // State and mode registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_CLEAR;
            rm_reg    <= 1'b0;
            xres_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            rm_reg    <= rm_next;
            xres_reg  <= xres_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        rm_next    = rm_reg;
        xres_next  = xres_reg;
        cmd        = '0;
        x_done     = 1'b0;
        x_val      = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.idle = 1'b1;
                if (stat.accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.op)
                    OP_ALLOC:
                    begin
                        if (stat.a_bad) begin
                            cmd.res_wr     = 1'b1;
                            cmd.res_status = ST_FAIL;
                            state_next     = S_DONE;
                        end else begin
                            cmd.a_init = 1'b1;
                            state_next = S_A_POP;
                        end
                    end
                    OP_FREE:
                    begin
                        if (stat.f_tier_bad) begin
                            cmd.res_wr     = 1'b1;
                            cmd.res_status = ST_FAIL;
                            state_next     = S_DONE;
                        end else if (!stat.f_fit) begin
                            cmd.res_wr     = 1'b1;
                            cmd.res_status = ST_NOT_ALLOC;
                            state_next     = S_DONE;
                        end else begin
                            state_next = S_F_CHK;
                        end
                    end
                    OP_QUERY:
                    begin
                        cmd.q_init = 1'b1;
                        state_next = S_Q_NEXT;
                    end
                    default:
                    begin
                        cmd.res_wr     = 1'b1;
                        cmd.res_status = ST_FAIL;
                        state_next     = S_DONE;
                    end
                endcase
            end
            S_A_POP:
            begin
                cmd.pop_rd = 1'b1;
                state_next = S_A_POPW;
            end
            S_A_POPW:
            begin
                cmd.pop_wr = 1'b1;
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                if (stat.k_at_e) begin
                    state_next = S_A_MARK;
                end else begin
                    cmd.split = 1'b1;
                end
            end
            S_A_MARK:
            begin
                cmd.a_mark     = 1'b1;
                cmd.res_wr     = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_alloc  = 1'b1;
                state_next     = S_DONE;
            end
            S_F_CHK:
            begin
                if (stat.f_can_merge) begin
                    cmd.walk_init = 1'b1;
                    rm_next       = 1'b1;
                    state_next    = S_W_RD;
                end else begin
                    rm_next    = 1'b0;
                    state_next = S_X_FIT;
                end
            end
            S_F_MERGE:
            begin
                cmd.merge  = 1'b1;
                state_next = S_F_CHK;
            end
            S_F_PUSH:
            begin
                cmd.f_push     = 1'b1;
                cmd.pbit       = xres_reg;
                cmd.res_wr     = 1'b1;
                cmd.res_status = ST_OK;
                state_next     = S_DONE;
            end
            S_Q_NEXT:
            begin
                if (stat.q_over) begin
                    cmd.res_wr     = 1'b1;
                    cmd.res_status = ST_NOT_ALLOC;
                    state_next     = S_DONE;
                end else begin
                    state_next = S_X_FIT;
                end
            end
            S_X_FIT:
            begin
                if (!stat.tgt_fits) begin
                    x_done = 1'b1;
                end else begin
                    cmd.x_rd   = 1'b1;
                    state_next = S_X_PB;
                end
            end
            S_X_PB:
            begin
                if (!stat.pair_q) begin
                    x_done = 1'b1;
                end else begin
                    cmd.walk_init = 1'b1;
                    rm_next       = 1'b0;
                    state_next    = S_W_RD;
                end
            end
            S_W_RD:
            begin
                if (!stat.walk_live) begin
                    // Target is not on the list.
                    if (rm_reg) begin
                        rm_next    = 1'b0;
                        state_next = S_X_FIT;
                    end else begin
                        state_next = S_H_RD;
                    end
                end else if (stat.walk_hit && !rm_reg) begin
                    x_done = 1'b1;
                end else begin
                    cmd.w_rd   = 1'b1;
                    state_next = S_W_CMP;
                end
            end
            S_W_CMP:
            begin
                if (stat.walk_hit && rm_reg) begin
                    cmd.unlink = 1'b1;
                    state_next = S_F_MERGE;
                end else if (stat.walk_hit) begin
                    x_done = 1'b1;
                end else begin
                    cmd.w_adv  = 1'b1;
                    state_next = S_W_RD;
                end
            end
            S_H_RD:
            begin
                if (stat.h_end) begin
                    x_done = 1'b1;
                    x_val  = 1'b1;
                end else begin
                    cmd.h_rd   = 1'b1;
                    state_next = S_H_CHK;
                end
            end
            S_H_CHK:
            begin
                if (stat.pair_q) begin
                    x_done = 1'b1;
                end else begin
                    cmd.h_adv  = 1'b1;
                    state_next = S_H_RD;
                end
            end
            S_DONE:
            begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Outcome of an exact-outstanding check.
        if (x_done) begin
            if (stat.op == OP_FREE) begin
                xres_next  = x_val;
                state_next = S_F_PUSH;
            end else if (x_val) begin
                cmd.res_wr     = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_query  = 1'b1;
                state_next     = S_DONE;
            end else begin
                cmd.tier_inc = 1'b1;
                state_next   = S_Q_NEXT;
            end
        end
    end

endmodule

[rtl/core/buddy_block_allocator_core.sv]
// Top level of the buddy block allocator: controller plus datapath.
// Usage:
//   req carries one word per operation: opcode (allocate, free, query), block_addr
//   and req_tier. rsp returns exactly one word per request: status, result_addr and
//   found_tier. cfg writes pool_base, pool_bytes, min_tier and max_tier by index;
//   it is always ready and must only be used while no request is in flight.
// Operation:
//   One request is worked on at a time. An allocate pops the head of the smallest
//   non-empty tier in range, splits it down one tier at a time, then marks its pair
//   bit. A free or query walks free lists and pair bits through the link memory and
//   the single-ported pair-bit memory, one list entry or pair bit at a time, so the
//   time taken depends on the list lengths and on the tier of the block.
// Reset:
//   All free lists are emptied at once. The pair-bit memory is then cleared by a
//   pass over its 8192 entries, one per cycle; req is not ready during that pass.
// Back-pressure:
//   The result waits in an output register while rsp is stalled; a new request is
//   accepted meanwhile, and its result is held until the register frees up.
`timescale 1ns / 1ps

module buddy_block_allocator_core (
    input logic       clk,
    input logic       rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp,
    bba_cfg_if.sink   cfg
);
    import bba_pkg::*;

    bba_cmd_t  cmd;
    bba_stat_t stat;

    // Sequencer.
    bba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    // Storage and arithmetic.
    bba_dpath u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .stat  (stat),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

endmodule
